/* hdl/mstg_pkg.sv */
// Shared types, register codes and constant functions of the tone generator.
// Depends on nothing; the other files that use it refer to it by scoped names.
package mstg_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP   = 2'd0,
      CSR_WAVE_SHAPE   = 2'd1,
      CSR_GAIN         = 2'd2,
      CSR_SAMPLE_BYTES = 2'd3
   } csr_index_type;

   // Wave shapes; the unused code plays silence
   typedef enum logic [1:0] {
      SHAPE_SINE     = 2'd0,
      SHAPE_SQUARE   = 2'd1,
      SHAPE_TRIANGLE = 2'd2
   } shape_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROM,
      ST_GAIN,
      ST_SCALE,
      ST_ROUND,
      ST_EMIT
   } back_state_type;

   // Live configuration seen by the back end
   typedef struct packed {
      shape_type   wave_shape;
      logic [15:0] gain;
      logic [1:0]  last_idx;   // bytes per sample minus one
   } cfg_type;

   localparam logic [63:0]        HALF_PI_Q30  = 64'd1686629713;
   localparam logic signed [16:0] WAVE_ONE     = 17'sd32768;
   localparam logic [3:0]         TAYLOR_TERMS = 4'd12;

   // floor(2^64 / ((2n)(2n+1))) + 1 for Taylor term n; multiply and keep the
   // top 64 bits for the exact quotient of any numerator below 2^54
   localparam logic [64:0] TWO_POW_64 = 65'd1 << 64;
   localparam logic [1:12][63:0] TAYLOR_RECIP = {
      64'(TWO_POW_64 / 65'd6)   + 64'd1,
      64'(TWO_POW_64 / 65'd20)  + 64'd1,
      64'(TWO_POW_64 / 65'd42)  + 64'd1,
      64'(TWO_POW_64 / 65'd72)  + 64'd1,
      64'(TWO_POW_64 / 65'd110) + 64'd1,
      64'(TWO_POW_64 / 65'd156) + 64'd1,
      64'(TWO_POW_64 / 65'd210) + 64'd1,
      64'(TWO_POW_64 / 65'd272) + 64'd1,
      64'(TWO_POW_64 / 65'd342) + 64'd1,
      64'(TWO_POW_64 / 65'd420) + 64'd1,
      64'(TWO_POW_64 / 65'd506) + 64'd1,
      64'(TWO_POW_64 / 65'd600) + 64'd1
   };

   // sin(x) in Q1.15 from x in Q2.30: truncating Taylor series, round half up.
   // Only evaluated at elaboration to fill the quarter-wave table.
   function automatic logic [15:0] sine_entry(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        num;
      logic [127:0]       wide;
      logic signed [63:0] sum;
      logic signed [63:0] q;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= int'(TAYLOR_TERMS); n++) begin
         num  = (term * x2) >> 30;
         wide = 128'(num) * 128'(TAYLOR_RECIP[n]);
         term = wide[127:64];
         if (n[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      q = (sum + 64'sd16384) >>> 15;
      if (q > 64'sd32768) begin
         q = 64'sd32768;
      end
      return q[15:0];
   endfunction

   // Full-scale PCM magnitude for 1..4 bytes
   function automatic logic [30:0] pcm_max(input logic [1:0] last_idx);
      logic [30:0] m;
      case (last_idx)
         2'd0:    m = 31'd127;
         2'd1:    m = 31'd32767;
         2'd2:    m = 31'd8388607;
         default: m = 31'd2147483647;
      endcase
      return m;
   endfunction

   // Byte count register to last byte index; zero acts as one, above four as four
   function automatic logic [1:0] byte_last_idx(input logic [2:0] sample_bytes);
      logic [1:0] li;
      case (sample_bytes) inside
         [3'd1:3'd4]: li = 2'(sample_bytes - 3'd1);
         3'd0:        li = 2'd0;
         default:     li = 2'd3;
      endcase
      return li;
   endfunction

endpackage

/* hdl/mstg_if.sv */
// Valid/ready channel interfaces of the tone generator: request and byte response.
// No dependencies.
interface mstg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface mstg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

/* hdl/multi_shape_tone_generator.sv */
// Top level of the DDS tone generator: config registers, front, queue, back.
// Depends on mstg_pkg.sv, mstg_if.sv, mstg_front.sv, mstg_fifo.sv, mstg_back.sv.
//
//   port       dir    handshake        payload
//   req_chan   in     valid/ready      restart (1)
//   rsp_chan   out    valid/ready      out_byte (8), last_byte (1)
//   csr_*      in     csr_we only      csr_index (2), csr_wdata (32)
//
// Sequence: the back end computes each sample by index multiply, table read,
//   gain multiply, PCM scale multiply and round/saturate, then sends its bytes
//   in turn; the back end works one sample at a time.
// Reset: synchronous, active high; clears phase, queue and back-end state and
//   loads the register defaults.
// Stalls: rsp_chan.ready low holds the current byte; the front keeps taking
//   requests until the two-entry phase queue is full.
module multi_shape_tone_generator #(
   parameter int PHASE_BITS       = 32,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   mstg_req_if.sink                            req_chan,
   mstg_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [mstg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mstg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers
   logic [31:0]         phase_step_ff, phase_step_in;
   mstg_pkg::shape_type wave_shape_ff, wave_shape_in;
   logic [15:0]         gain_ff, gain_in;
   logic [2:0]          sample_bytes_ff, sample_bytes_in;

   mstg_pkg::cfg_type   cfg;

   // queue wiring
   logic                  push_valid;
   logic                  push_ready;
   logic [PHASE_BITS-1:0] push_phase;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [PHASE_BITS-1:0] pop_phase;

   always_comb begin
      phase_step_in   = phase_step_ff;
      wave_shape_in   = wave_shape_ff;
      gain_in         = gain_ff;
      sample_bytes_in = sample_bytes_ff;
      if (csr_we) begin
         case (mstg_pkg::csr_index_type'(csr_index))
            mstg_pkg::CSR_PHASE_STEP:   phase_step_in   = csr_wdata;
            mstg_pkg::CSR_WAVE_SHAPE:   wave_shape_in   = mstg_pkg::shape_type'(csr_wdata[1:0]);
            mstg_pkg::CSR_GAIN:         gain_in         = csr_wdata[15:0];
            mstg_pkg::CSR_SAMPLE_BYTES: sample_bytes_in = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= 32'd39370534;    // 440 Hz at 48 kHz
         wave_shape_ff   <= mstg_pkg::SHAPE_TRIANGLE;
         gain_ff         <= 16'd32768;       // unity
         sample_bytes_ff <= 3'd2;
      end else begin
         phase_step_ff   <= phase_step_in;
         wave_shape_ff   <= wave_shape_in;
         gain_ff         <= gain_in;
         sample_bytes_ff <= sample_bytes_in;
      end
   end

   // Config is to be changed only while idle; the block does not enforce it, and the back end reads it live.
   always_comb begin
      cfg.wave_shape = wave_shape_ff;
      cfg.gain       = gain_ff;
      cfg.last_idx   = mstg_pkg::byte_last_idx(sample_bytes_ff);
   end

   // Front: restart and phase accumulation, one request per cycle while the phase queue has room
   mstg_front #(
      .PHASE_BITS (PHASE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .phase_step (phase_step_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_phase (push_phase)
   );

   // Phase queue decouples request intake from byte output
   mstg_fifo #(
      .WIDTH (PHASE_BITS)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_phase),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_phase)
   );

   // Back: wave, gain, PCM conversion and byte serialization
   mstg_back #(
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_phase (pop_phase),
      .rsp       (rsp_chan)
   );

endmodule

/* hdl/mstg_front.sv */
// Front end: takes requests, applies restart, advances the phase accumulator.
// Depends on mstg_if.sv (request interface).
module mstg_front #(
   parameter int PHASE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   mstg_req_if.sink              req,
   input  logic [31:0]           phase_step,
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic [PHASE_BITS-1:0] push_phase
);

   logic [PHASE_BITS-1:0] phase_acc_ff;
   logic [PHASE_BITS-1:0] phase_acc_in;
   logic [PHASE_BITS-1:0] start_phase;
   logic [PHASE_BITS+31:0] phase_sum;
   logic                  accept;

   always_comb begin
      accept       = req.valid && push_ready;
      start_phase  = req.restart ? '0 : phase_acc_ff;
      // sample uses the current phase, then the accumulator steps
      phase_sum    = (PHASE_BITS+32)'(start_phase) + (PHASE_BITS+32)'(phase_step);
      phase_acc_in = accept ? phase_sum[PHASE_BITS-1:0] : phase_acc_ff;
      req.ready    = push_ready;
      push_valid   = req.valid;
      push_phase   = start_phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
      end else begin
         phase_acc_ff <= phase_acc_in;
      end
   end

endmodule

/* hdl/mstg_fifo.sv */
// Two-entry queue of sample phases between front and back end.
// No dependencies.
module mstg_fifo #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             push;
   logic             pop;

   always_comb begin
      push_ready = (count_ff != 2'd2);
      pop_valid  = (count_ff != 2'd0);
      pop_data   = mem_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = wr_ptr_ff ^ push;
      rd_ptr_in  = rd_ptr_ff ^ pop;
      count_in   = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/mstg_back.sv */
// Back end: wave lookup, gain and PCM scaling, rounding, byte serializer.
// Depends on mstg_pkg.sv (types, table function) and mstg_if.sv (response).
module mstg_back #(
   parameter int PHASE_BITS       = 32,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mstg_pkg::cfg_type     cfg,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  logic [PHASE_BITS-1:0] pop_phase,
   mstg_rsp_if.source            rsp
);

   localparam int AW     = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int RW     = PHASE_BITS - 2;
   localparam int PRODW  = RW + AW;
   localparam int TRI_SHR = (PHASE_BITS >= 17) ? PHASE_BITS - 17 : 0;
   localparam int TRI_SHL = (PHASE_BITS < 17) ? 17 - PHASE_BITS : 0;
   localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

   // Quarter-wave table, built at elaboration
   logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];

   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [63:0] ANGLE = (mstg_pkg::HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      assign sine_rom[k] = mstg_pkg::sine_entry(ANGLE);
   end

   mstg_pkg::back_state_type state_ff, state_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [15:0]           rom_ff, rom_in;
   logic [30:0]           mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [61:0]           scaled_ff, scaled_in;
   logic [31:0]           bits_ff, bits_in;
   logic [1:0]            cnt_ff, cnt_in;

   // datapath terms
   logic [PRODW-1:0]        idx_prod;
   logic [AW-1:0]           idx_i;
   logic [AW-1:0]           idx_sel;
   logic [PHASE_BITS-1:0]   tri_d;
   logic [PHASE_BITS:0]     tri_s;
   logic signed [17:0]      tri_w;
   logic signed [16:0]      wave;
   logic signed [33:0]      prod;
   logic [33:0]             prod_abs;
   logic [62:0]             rnd_sum;
   logic [32:0]             rounded;
   logic [31:0]             lim;
   logic [31:0]             mag_sat;
   logic [31:0]             pcm;

   // table index from the phase below the quadrant bits
   always_comb begin
      idx_prod = PRODW'(pop_phase[RW-1:0]) * PRODW'(SINE_TABLE_DEPTH);
      idx_i    = idx_prod[RW +: AW];
      idx_sel  = pop_phase[PHASE_BITS-2] ? AW'(SINE_TABLE_DEPTH) - idx_i : idx_i;
   end

   // wave value in Q1.15 and gain product
   always_comb begin
      tri_d = phase_ff[PHASE_BITS-1] ? {1'b0, phase_ff[PHASE_BITS-2:0]}
                                     : PHASE_HALF - phase_ff;
      tri_s = ({1'b0, tri_d} >> TRI_SHR) << TRI_SHL;
      tri_w = 18'sd32768 - $signed({1'b0, tri_s[16:0]});
      case (cfg.wave_shape)
         mstg_pkg::SHAPE_SINE: begin
            wave = phase_ff[PHASE_BITS-1] ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});
         end
         mstg_pkg::SHAPE_SQUARE: begin
            wave = phase_ff[PHASE_BITS-1] ? -mstg_pkg::WAVE_ONE : mstg_pkg::WAVE_ONE;
         end
         mstg_pkg::SHAPE_TRIANGLE: begin
            wave = tri_w[16:0];
         end
         default: begin
            wave = '0;
         end
      endcase
      prod     = wave * $signed({1'b0, cfg.gain});
      prod_abs = prod[33] ? 34'(-prod) : 34'(prod);
   end

   // round half away from zero, then saturate to the byte format
   always_comb begin
      rnd_sum = {1'b0, scaled_ff} + (63'd1 << 29);
      rounded = rnd_sum[62:30];
      lim     = {1'b0, mstg_pkg::pcm_max(cfg.last_idx)} + 32'(neg_ff);
      mag_sat = (rounded > {1'b0, lim}) ? lim : rounded[31:0];
      pcm     = neg_ff ? -mag_sat : mag_sat;
      if (cfg.last_idx == 2'd0) begin
         pcm[7] = ~pcm[7];   // 8-bit is offset binary
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      rom_in    = rom_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      scaled_in = scaled_ff;
      bits_in   = bits_ff;
      cnt_in    = cnt_ff;
      pop_ready = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         mstg_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               phase_in = pop_phase;
               idx_in   = idx_sel;
               cnt_in   = 2'd0;
               state_in = mstg_pkg::ST_ROM;
            end
         end
         mstg_pkg::ST_ROM: begin
            rom_in   = sine_rom[idx_ff];
            state_in = mstg_pkg::ST_GAIN;
         end
         mstg_pkg::ST_GAIN: begin
            neg_in   = prod[33];
            mag_in   = prod_abs[30:0];
            state_in = mstg_pkg::ST_SCALE;
         end
         mstg_pkg::ST_SCALE: begin
            scaled_in = 62'(mag_ff) * 62'(mstg_pkg::pcm_max(cfg.last_idx));
            state_in  = mstg_pkg::ST_ROUND;
         end
         mstg_pkg::ST_ROUND: begin
            bits_in  = pcm;
            state_in = mstg_pkg::ST_EMIT;
         end
         mstg_pkg::ST_EMIT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               bits_in = bits_ff >> 8;
               cnt_in  = cnt_ff + 2'd1;
               if (cnt_ff == cfg.last_idx) begin
                  state_in = mstg_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = mstg_pkg::ST_IDLE;
         end
      endcase
      rsp.out_byte  = bits_ff[7:0];
      rsp.last_byte = (cnt_ff == cfg.last_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mstg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff  <= phase_in;
      idx_ff    <= idx_in;
      rom_ff    <= rom_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      scaled_ff <= scaled_in;
      bits_ff   <= bits_in;
      cnt_ff    <= cnt_in;
   end

endmodule

/* hdl/mstg_checker.sv */
// Port-level checks of the tone generator and the bind that attaches them.
// Depends on mstg_pkg.sv and multi_shape_tone_generator.sv.
module mstg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [7:0]                       rsp_out_byte,
   input logic                             rsp_last_byte,
   input logic                             csr_we,
   input logic [mstg_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [mstg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [2:0] sb_ff, sb_in;       // shadow of sample_bytes
   logic [1:0] cnt_ff, cnt_in;     // byte position in current sample
   logic [2:0] pend_ff, pend_in;   // requests not yet fully answered
   logic       req_acc;
   logic       rsp_acc;
   logic       rsp_done;

   always_comb begin
      req_acc  = req_valid && req_ready;
      rsp_acc  = rsp_valid && rsp_ready;
      rsp_done = rsp_acc && rsp_last_byte;
      sb_in    = sb_ff;
      if (csr_we && (mstg_pkg::csr_index_type'(csr_index) == mstg_pkg::CSR_SAMPLE_BYTES)) begin
         sb_in = csr_wdata[2:0];
      end
      cnt_in  = rsp_done ? 2'd0 : (rsp_acc ? cnt_ff + 2'd1 : cnt_ff);
      pend_in = pend_ff + 3'(req_acc) - 3'(rsp_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff   <= 3'd2;
         cnt_ff  <= 2'd0;
         pend_ff <= 3'd0;
      end else begin
         sb_ff   <= sb_in;
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_byte))
      else $error("response dropped or changed while stalled");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_byte == (cnt_ff == mstg_pkg::byte_last_idx(sb_ff))))
      else $error("last_byte does not match configured sample width");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 3'd0))
      else $error("response byte without an outstanding request");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == 3'd0) |-> req_ready)
      else $error("request stalled while nothing is outstanding");

endmodule

bind multi_shape_tone_generator mstg_checker u_mstg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_byte  (rsp_chan.out_byte),
   .rsp_last_byte (rsp_chan.last_byte),
   .csr_we        (csr_we),
   .csr_index     (csr_index),
   .csr_wdata     (csr_wdata)
);
